FILE: hdl/dvw_pkg.sv
// Shared types, codes and constants of the distinct-vectors watch propagator.
`timescale 1ns / 1ps
package dvw_pkg;

  localparam int MAX_LENGTH_DEFAULT = 64;
  localparam int CMD_W = 2;
  localparam int POS_W = 6;
  localparam int VAL_W = 32;
  localparam int CFG_W = 7;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd2;

  typedef enum logic {
    RD_MINE  = 1'b0,
    RD_OTHER = 1'b1
  } rd_sel_t;

  typedef enum logic [2:0] {
    W_NONE   = 3'd0,
    W_CLEAR  = 3'd1,
    W_FIRST  = 3'd2,
    W_SECOND = 3'd3,
    W_MINE   = 3'd4
  } watch_op_t;

  typedef enum logic [1:0] {
    RES_ZERO    = 2'd0,
    RES_DEDUCE  = 2'd1,
    RES_RESOLVE = 2'd2
  } res_op_t;

  typedef struct packed {
    logic      accept;
    logic      store;
    rd_sel_t   rd_sel;
    logic      scan_go;
    watch_op_t watch_op;
    logic      finish;
    res_op_t   res_op;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] item_cmd;
    logic             upd_hit;
    logic             probe_cw;
    logic             probe_osf;
    logic             scan_active;
    logic             scan_done;
    logic             scan_found;
  } dp_sts_t;

endpackage

FILE: hdl/dvw_datapath.sv
// Datapath: domain tables, watches, sentinel scan counter and result registers.
`timescale 1ns / 1ps
module dvw_datapath #(
  parameter int MAX_LENGTH = dvw_pkg::MAX_LENGTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  dvw_pkg::dp_cmd_t                ctl,
  output dvw_pkg::dp_sts_t                sts,
  input  logic [dvw_pkg::CMD_W-1:0]       cmd,
  input  logic                            side,
  input  logic [dvw_pkg::POS_W-1:0]       position,
  input  logic                            is_fixed,
  input  logic signed [dvw_pkg::VAL_W-1:0] fixed_value,
  input  logic                            cfg_we,
  input  logic [dvw_pkg::CFG_W-1:0]       cfg_data,
  output logic                            done,
  output logic                            status,
  output logic                            remove_valid,
  output logic                            remove_side,
  output logic [dvw_pkg::POS_W-1:0]       remove_position,
  output logic signed [dvw_pkg::VAL_W-1:0] remove_value
);
  import dvw_pkg::*;

  localparam int IDXW = $clog2(MAX_LENGTH);
  localparam int LENW = $clog2(MAX_LENGTH + 1);
  localparam int CMPW = (LENW > CFG_W) ? LENW : CFG_W;

  // latched transaction
  logic [CMD_W-1:0] cmd_q;
  logic             side_q;
  logic [POS_W-1:0] pos_q;
  logic             fixed_q;
  logic [VAL_W-1:0] value_q;

  logic [MAX_LENGTH-1:0] x_flags;
  logic [MAX_LENGTH-1:0] y_flags;
  logic [VAL_W-1:0]      x_mem [MAX_LENGTH];
  logic [VAL_W-1:0]      y_mem [MAX_LENGTH];
  logic [VAL_W-1:0]      x_rd;
  logic [VAL_W-1:0]      y_rd;
  logic [IDXW-1:0]       probe_idx;

  logic [IDXW-1:0] watch_first;
  logic [IDXW-1:0] watch_second;
  logic [LENW-1:0] len;
  logic [LENW-1:0] len_next;
  logic [LENW-1:0] scan_cnt;
  logic            scan_active;
  logic            cand_valid;
  logic            mine_first;

  logic             res_status;
  logic             res_valid;
  logic             res_side;
  logic [POS_W-1:0] res_pos;
  logic [VAL_W-1:0] res_value;

  logic [CMPW-1:0] cfg_c;
  logic [CMPW-1:0] pos_c;
  logic [IDXW-1:0] pos_idx;
  logic            pos_in_tbl;
  logic            pos_in_len;
  logic            hit_first;
  logic            hit_second;
  logic            mem_we;
  logic [IDXW-1:0] mine_idx;
  logic [IDXW-1:0] other_idx;
  logic            scan_issue;
  logic [IDXW-1:0] rd_addr;
  logic            pfx;
  logic            pfy;
  logic            peq;
  logic            probe_cw;
  logic            scan_hit;
  logic            scan_last;
  logic            scan_done;
  logic [CMPW-1:0] probe_c;

  // clamp the length when it is written
  assign cfg_c = CMPW'(cfg_data);
  always_comb begin
    if (cfg_c < CMPW'(2)) begin
      len_next = LENW'(2);
    end else if (cfg_c > CMPW'(MAX_LENGTH)) begin
      len_next = LENW'(MAX_LENGTH);
    end else begin
      len_next = cfg_c[LENW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= LENW'(2);
    end else if (cfg_we) begin
      len <= len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_q   <= cmd;
      side_q  <= side;
      pos_q   <= position;
      fixed_q <= is_fixed;
      value_q <= fixed_value;
    end
  end

  assign pos_c      = CMPW'(pos_q);
  assign pos_idx    = pos_c[IDXW-1:0];
  assign pos_in_tbl = pos_c < CMPW'(MAX_LENGTH);
  assign pos_in_len = pos_c < CMPW'(len);
  assign hit_first  = pos_c == CMPW'(watch_first);
  assign hit_second = pos_c == CMPW'(watch_second);
  assign mem_we     = ctl.store && pos_in_tbl && (cmd_q == CMD_LOAD || cmd_q == CMD_UPDATE);

  always_ff @(posedge clk) begin
    if (ctl.store) begin
      mine_first <= hit_first;
    end
  end

  assign mine_idx   = mine_first ? watch_first : watch_second;
  assign other_idx  = mine_first ? watch_second : watch_first;
  assign scan_issue = scan_active && (scan_cnt < len);

  always_comb begin
    if (scan_issue) begin
      rd_addr = scan_cnt[IDXW-1:0];
    end else if (ctl.rd_sel == RD_OTHER) begin
      rd_addr = other_idx;
    end else begin
      rd_addr = mine_idx;
    end
  end

  // value tables, registered read
  always_ff @(posedge clk) begin
    if (mem_we && !side_q) begin
      x_mem[pos_idx] <= value_q;
    end
    if (mem_we && side_q) begin
      y_mem[pos_idx] <= value_q;
    end
    x_rd      <= x_mem[rd_addr];
    y_rd      <= y_mem[rd_addr];
    probe_idx <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_flags <= '0;
      y_flags <= '0;
    end else if (mem_we) begin
      if (side_q) begin
        y_flags[pos_idx] <= fixed_q;
      end else begin
        x_flags[pos_idx] <= fixed_q;
      end
    end
  end

  // evaluation of the entry read last cycle
  assign pfx       = x_flags[probe_idx];
  assign pfy       = y_flags[probe_idx];
  assign peq       = x_rd == y_rd;
  assign probe_cw  = !(pfx && pfy && peq);
  assign probe_c   = CMPW'(probe_idx);
  assign scan_hit  = cand_valid && (probe_idx != watch_first) &&
                     (probe_idx != watch_second) && probe_cw;
  assign scan_last = (probe_c + CMPW'(1)) == CMPW'(len);
  assign scan_done = cand_valid && (scan_hit || scan_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_active <= 1'b0;
      cand_valid  <= 1'b0;
      scan_cnt    <= '0;
    end else if (ctl.scan_go) begin
      scan_active <= 1'b1;
      cand_valid  <= 1'b0;
      scan_cnt    <= '0;
    end else if (scan_active) begin
      if (scan_done) begin
        scan_active <= 1'b0;
        cand_valid  <= 1'b0;
      end else if (scan_issue) begin
        scan_cnt   <= scan_cnt + LENW'(1);
        cand_valid <= 1'b1;
      end else begin
        cand_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      watch_first  <= '0;
      watch_second <= '0;
    end else begin
      case (ctl.watch_op)
        W_CLEAR: begin
          watch_first  <= '0;
          watch_second <= '0;
        end
        W_FIRST: begin
          watch_first <= scan_hit ? probe_idx : '0;
        end
        W_SECOND: begin
          if (scan_hit) begin
            watch_second <= probe_idx;
          end else begin
            watch_second <= (watch_first == '0) ? IDXW'(1) : '0;
          end
        end
        W_MINE: begin
          if (mine_first) begin
            watch_first <= probe_idx;
          end else begin
            watch_second <= probe_idx;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.finish;
    end
  end

  // the free side loses the value of the fixed side: X fixed prunes Y
  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      res_status <= 1'b0;
      res_valid  <= 1'b0;
      res_side   <= 1'b0;
      res_pos    <= '0;
      res_value  <= '0;
      case (ctl.res_op)
        RES_DEDUCE: begin
          res_valid <= 1'b1;
          res_side  <= pfx;
          res_pos   <= probe_c[POS_W-1:0];
          res_value <= pfx ? x_rd : y_rd;
        end
        RES_RESOLVE: begin
          if (pfx && pfy) begin
            res_status <= peq;
          end else if (pfx || pfy) begin
            res_valid <= 1'b1;
            res_side  <= pfx;
            res_pos   <= probe_c[POS_W-1:0];
            res_value <= pfx ? x_rd : y_rd;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign status          = res_status;
  assign remove_valid    = res_valid;
  assign remove_side     = res_side;
  assign remove_position = res_pos;
  assign remove_value    = $signed(res_value);

  assign sts.item_cmd    = cmd_q;
  assign sts.upd_hit     = pos_in_len && (hit_first || hit_second);
  assign sts.probe_cw    = probe_cw;
  assign sts.probe_osf   = pfx != pfy;
  assign sts.scan_active = scan_active;
  assign sts.scan_done   = scan_done;
  assign sts.scan_found  = scan_hit;

endmodule

FILE: hdl/dvw_controller.sv
// Controller: sequences store, probe reads, sentinel scans and the result.
`timescale 1ns / 1ps
module dvw_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  output dvw_pkg::dp_cmd_t ctl,
  input  dvw_pkg::dp_sts_t sts
);
  import dvw_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE      = 11'b00000000001,
    S_STORE     = 11'b00000000010,
    S_RD_MINE   = 11'b00000000100,
    S_CHK_MINE  = 11'b00000001000,
    S_CHK_OTHER = 11'b00000010000,
    S_CHK_MINE2 = 11'b00000100000,
    S_SCAN_UPD  = 11'b00001000000,
    S_RD_OTHER  = 11'b00010000000,
    S_RESOLVE   = 11'b00100000000,
    S_SCAN1     = 11'b01000000000,
    S_SCAN2     = 11'b10000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = state != S_IDLE;

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.accept = 1'b1;
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        ctl.store = 1'b1;
        case (sts.item_cmd)
          CMD_START: begin
            ctl.watch_op = W_CLEAR;
            ctl.scan_go  = 1'b1;
            state_next   = S_SCAN1;
          end
          CMD_UPDATE: begin
            if (sts.upd_hit) begin
              state_next = S_RD_MINE;
            end else begin
              ctl.finish = 1'b1;
              state_next = S_IDLE;
            end
          end
          default: begin
            ctl.finish = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_RD_MINE: begin
        ctl.rd_sel = RD_MINE;
        state_next = S_CHK_MINE;
      end
      S_CHK_MINE: begin
        if (!sts.probe_cw) begin
          ctl.scan_go = 1'b1;
          state_next  = S_SCAN_UPD;
        end else begin
          ctl.rd_sel = RD_OTHER;
          state_next = S_CHK_OTHER;
        end
      end
      S_CHK_OTHER: begin
        if (sts.probe_cw) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          ctl.rd_sel = RD_MINE;
          state_next = S_CHK_MINE2;
        end
      end
      S_CHK_MINE2: begin
        ctl.finish = 1'b1;
        ctl.res_op = sts.probe_osf ? RES_DEDUCE : RES_ZERO;
        state_next = S_IDLE;
      end
      S_SCAN_UPD: begin
        if (sts.scan_done) begin
          if (sts.scan_found) begin
            ctl.watch_op = W_MINE;
            ctl.finish   = 1'b1;
            state_next   = S_IDLE;
          end else begin
            state_next = S_RD_OTHER;
          end
        end
      end
      S_RD_OTHER: begin
        ctl.rd_sel = RD_OTHER;
        state_next = S_RESOLVE;
      end
      S_RESOLVE: begin
        ctl.finish = 1'b1;
        ctl.res_op = RES_RESOLVE;
        state_next = S_IDLE;
      end
      S_SCAN1: begin
        if (sts.scan_done) begin
          ctl.watch_op = W_FIRST;
          ctl.scan_go  = 1'b1;
          state_next   = S_SCAN2;
        end
      end
      S_SCAN2: begin
        if (sts.scan_done) begin
          ctl.watch_op = W_SECOND;
          ctl.finish   = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/distinct_vectors_watch_propagator_core.sv
// Top level of the distinct-vectors watch propagator.
`timescale 1ns / 1ps
// Usage notes
//  - Input: a transaction is taken at a rising edge with start high and busy
//    low; cmd, side, position, is_fixed and fixed_value are captured then.
//  - Output: every transaction produces exactly one result, presented for a
//    single cycle with done high. The receiver cannot stall; the result
//    registers hold until the next transaction completes.
//  - Config: cfg_we/cfg_data write vector_length (clamped to 2..MAX_LENGTH);
//    write it only while busy is low; the block does not enforce this.
//  - Sequence after the accept and store, L = vector_length:
//      load, undefined cmd, update off the watches: result issued from store
//      update on a watch, no scan: probe reads of the watched positions
//      update on a watch with sentinel scan: scan of up to L positions
//      start (two sentinel scans): each scan of up to L positions
//    The scans read one position per cycle from the X and Y value tables,
//    each a single-read-port memory.
//  - busy is high from the accept until the result cycle; a new transaction
//    can be accepted in the cycle that done is high.
//  - Reset (rst, synchronous): fixed flags clear, both watches at position 0,
//    vector_length 2, no result pending. Value tables are not cleared.
module distinct_vectors_watch_propagator_core #(
  parameter int MAX_LENGTH = dvw_pkg::MAX_LENGTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [dvw_pkg::CMD_W-1:0]        cmd,
  input  logic                             side,
  input  logic [dvw_pkg::POS_W-1:0]        position,
  input  logic                             is_fixed,
  input  logic signed [dvw_pkg::VAL_W-1:0] fixed_value,
  input  logic                             cfg_we,
  input  logic [dvw_pkg::CFG_W-1:0]        cfg_data,
  output logic                             done,
  output logic                             status,
  output logic                             remove_valid,
  output logic                             remove_side,
  output logic [dvw_pkg::POS_W-1:0]        remove_position,
  output logic signed [dvw_pkg::VAL_W-1:0] remove_value
);
  import dvw_pkg::*;

  dp_cmd_t ctl;
  dp_sts_t sts;

  // sequencing of store, probe reads and scans
  dvw_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .ctl   (ctl),
    .sts   (sts)
  );

  // tables, watches, scan counter, result registers
  dvw_datapath #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .sts             (sts),
    .cmd             (cmd),
    .side            (side),
    .position        (position),
    .is_fixed        (is_fixed),
    .fixed_value     (fixed_value),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .done            (done),
    .status          (status),
    .remove_valid    (remove_valid),
    .remove_side     (remove_side),
    .remove_position (remove_position),
    .remove_value    (remove_value)
  );

  // result is only issued as the controller returns to idle
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while controller busy");

  // failure and a prune request are never reported together
  a_fail_no_prune: assert property (@(posedge clk) disable iff (rst)
    done |-> !(status && remove_valid))
    else $error("failure reported with a prune request");

  // an accepted transaction keeps the controller busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start");

  // a running scan belongs to a transaction in progress
  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    sts.scan_active |-> busy)
    else $error("sentinel scan running while idle");

endmodule
